// ===== rtl/dcbc_pkg.sv =====
// Package: DES tables, permutation and round functions for the DES-CBC block.
package dcbc_pkg;

  localparam int unsigned RoundsDef = 16;
  localparam logic [63:0] KeyReset = 64'h0235_41F3_4F20_0F88;
  localparam int unsigned CfgAddrW = 4;
  localparam logic [CfgAddrW-1:0] RegKeyAddr = 4'h0;
  localparam logic [CfgAddrW-1:0] RegIvAddr = 4'h8;

  typedef enum logic {
    ReqEncrypt = 1'b0,
    ReqDecrypt = 1'b1
  } req_e;

  typedef logic [7:0] tab64_t [64];
  typedef logic [7:0] tab56_t [56];
  typedef logic [7:0] tab48_t [48];
  typedef logic [7:0] tab32_t [32];
  typedef logic [1:0] tab16_t [16];
  typedef logic [3:0] sbox_t [8][64];

  localparam tab64_t TabIp = '{
    58,50,42,34,26,18,10,2, 60,52,44,36,28,20,12,4,
    62,54,46,38,30,22,14,6, 64,56,48,40,32,24,16,8,
    57,49,41,33,25,17,9,1,  59,51,43,35,27,19,11,3,
    61,53,45,37,29,21,13,5, 63,55,47,39,31,23,15,7};
  localparam tab64_t TabFp = '{
    40,8,48,16,56,24,64,32, 39,7,47,15,55,23,63,31,
    38,6,46,14,54,22,62,30, 37,5,45,13,53,21,61,29,
    36,4,44,12,52,20,60,28, 35,3,43,11,51,19,59,27,
    34,2,42,10,50,18,58,26, 33,1,41,9,49,17,57,25};
  localparam tab48_t TabE = '{
    32,1,2,3,4,5, 4,5,6,7,8,9, 8,9,10,11,12,13, 12,13,14,15,16,17,
    16,17,18,19,20,21, 20,21,22,23,24,25, 24,25,26,27,28,29, 28,29,30,31,32,1};
  localparam tab32_t TabP = '{
    16,7,20,21,29,12,28,17, 1,15,23,26,5,18,31,10,
    2,8,24,14,32,27,3,9, 19,13,30,6,22,11,4,25};
  localparam tab56_t TabPc1 = '{
    57,49,41,33,25,17,9,1,58,50,42,34,26,18,10,2,59,51,43,35,27,19,11,3,60,52,44,36,
    63,55,47,39,31,23,15,7,62,54,46,38,30,22,14,6,61,53,45,37,29,21,13,5,28,20,12,4};
  localparam tab48_t TabPc2 = '{
    14,17,11,24,1,5,3,28,15,6,21,10,23,19,12,4,26,8,16,7,27,20,13,2,
    41,52,31,37,47,55,30,40,51,45,33,48,44,49,39,56,34,53,46,42,50,36,29,32};
  localparam tab16_t TabRot = '{1,1,2,2,2,2,2,2,1,2,2,2,2,2,2,1};
  localparam sbox_t TabS = '{
    '{14,4,13,1,2,15,11,8,3,10,6,12,5,9,0,7, 0,15,7,4,14,2,13,1,10,6,12,11,9,5,3,8,
      4,1,14,8,13,6,2,11,15,12,9,7,3,10,5,0, 15,12,8,2,4,9,1,7,5,11,3,14,10,0,6,13},
    '{15,1,8,14,6,11,3,4,9,7,2,13,12,0,5,10, 3,13,4,7,15,2,8,14,12,0,1,10,6,9,11,5,
      0,14,7,11,10,4,13,1,5,8,12,6,9,3,2,15, 13,8,10,1,3,15,4,2,11,6,7,12,0,5,14,9},
    '{10,0,9,14,6,3,15,5,1,13,12,7,11,4,2,8, 13,7,0,9,3,4,6,10,2,8,5,14,12,11,15,1,
      13,6,4,9,8,15,3,0,11,1,2,12,5,10,14,7, 1,10,13,0,6,9,8,7,4,15,14,3,11,5,2,12},
    '{7,13,14,3,0,6,9,10,1,2,8,5,11,12,4,15, 13,8,11,5,6,15,0,3,4,7,2,12,1,10,14,9,
      10,6,9,0,12,11,7,13,15,1,3,14,5,2,8,4, 3,15,0,6,10,1,13,8,9,4,5,11,12,7,2,14},
    '{2,12,4,1,7,10,11,6,8,5,3,15,13,0,14,9, 14,11,2,12,4,7,13,1,5,0,15,10,3,9,8,6,
      4,2,1,11,10,13,7,8,15,9,12,5,6,3,0,14, 11,8,12,7,1,14,2,13,6,15,0,9,10,4,5,3},
    '{12,1,10,15,9,2,6,8,0,13,3,4,14,7,5,11, 10,15,4,2,7,12,9,5,6,1,13,14,0,11,3,8,
      9,14,15,5,2,8,12,3,7,0,4,10,1,13,11,6, 4,3,2,12,9,5,15,10,11,14,1,7,6,0,8,13},
    '{4,11,2,14,15,0,8,13,3,12,9,7,5,10,6,1, 13,0,11,7,4,9,1,10,14,3,5,12,2,15,8,6,
      1,4,11,13,12,3,7,14,10,15,6,8,0,5,9,2, 6,11,13,8,1,4,10,7,9,5,0,15,14,2,3,12},
    '{13,2,8,4,6,15,11,1,10,9,3,14,5,0,12,7, 1,15,13,8,10,3,7,4,12,5,6,11,0,14,9,2,
      7,11,4,1,9,12,14,2,0,6,10,13,15,3,5,8, 2,1,14,7,4,10,8,13,15,12,9,0,3,5,6,11}};

  function automatic logic [63:0] perm_ip(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(TabIp[i])];
    return o;
  endfunction

  function automatic logic [63:0] perm_fp(input logic [63:0] v);
    logic [63:0] o;
    for (int i = 0; i < 64; i++) o[63-i] = v[64-int'(TabFp[i])];
    return o;
  endfunction

  function automatic logic [55:0] perm_pc1(input logic [63:0] v);
    logic [55:0] o;
    for (int i = 0; i < 56; i++) o[55-i] = v[64-int'(TabPc1[i])];
    return o;
  endfunction

  function automatic logic [47:0] perm_pc2(input logic [55:0] v);
    logic [47:0] o;
    for (int i = 0; i < 48; i++) o[47-i] = v[56-int'(TabPc2[i])];
    return o;
  endfunction

  function automatic logic [27:0] rot28(input logic [27:0] v, input logic [1:0] s);
    return (s == 2'd2) ? {v[25:0], v[27:26]} : {v[26:0], v[27]};
  endfunction

  function automatic logic [31:0] feistel(input logic [31:0] r, input logic [47:0] k);
    logic [47:0] e;
    logic [31:0] so;
    logic [31:0] o;
    logic [5:0] six;
    for (int i = 0; i < 48; i++) e[47-i] = r[32-int'(TabE[i])];
    e = e ^ k;
    for (int s = 0; s < 8; s++) begin
      six = e[47-6*s -: 6];
      so[31-4*s -: 4] = TabS[s][{six[5], six[0], six[4:1]}];
    end
    for (int i = 0; i < 32; i++) o[31-i] = so[32-int'(TabP[i])];
    return o;
  endfunction

endpackage

// ===== rtl/dcbc_if.sv =====
// Interfaces: valid/ready channels for request and result beats.
interface dcbc_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [63:0] in_block;
  logic        first_block;
  modport source (output valid, req_type, in_block, first_block, input ready);
  modport sink (input valid, req_type, in_block, first_block, output ready);
endinterface

interface dcbc_rsp_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_block;
  modport source (output valid, out_block, input ready);
  modport sink (input valid, out_block, output ready);
endinterface

// ===== rtl/dcbc_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module dcbc_ram #(
  parameter int unsigned Width = 48,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

// ===== rtl/des_cbc_block_cipher_top.sv =====
// Top level: DES-CBC engine, round keys in RAM, one Feistel round per cycle unless held.
//
//   channel   dir  handshake        payload
//   req       in   valid/ready      req_type, in_block, first_block
//   rsp       out  valid/ready      out_block
//   cfg       in   APB write/read   cipher_key @0x0, init_vector @0x8
//
// The first round key is read from the RAM in the accepting cycle, then one
// round runs per cycle from its registered read port unless the block is held.
// A new block can be accepted in the last round of the previous one.
// After reset and after each key write the schedule is rebuilt into the RAM;
// no block is taken while it is rebuilt.
// The result sits in an output register; a finished block holds in its last
// round while that register is still full, and no block is taken meanwhile.
module des_cbc_block_cipher_top
  import dcbc_pkg::*;
#(
  parameter int unsigned Rounds = RoundsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  dcbc_req_if.sink                      req,
  dcbc_rsp_if.source                    rsp,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dcbc_pkg::CfgAddrW-1:0] paddr,
  input  logic [63:0]                   pwdata,
  output logic [63:0]                   prdata,
  output logic                          pready
);
  localparam int unsigned RW = $clog2(Rounds);

  typedef enum logic [3:0] {
    StKey  = 4'b0001,
    StIdle = 4'b0010,
    StLoad = 4'b0100,
    StRun  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic [63:0] key_q, iv_q, enc_q, dec_q;
  logic [27:0] c_q, d_q;
  logic [RW-1:0] cnt_q;
  logic [31:0] l_q, r_q;
  logic dir_q;
  logic [63:0] blk_q, chain_q;
  logic [63:0] out_q;
  logic out_v_q;
  logic key_we;
  logic [27:0] c_n, d_n;
  logic [RW-1:0] raddr;
  logic [47:0] rk;
  logic [55:0] pc1;
  logic [63:0] ipv, fpv, xin;
  logic [31:0] fo;
  logic acc, done, wr;
  logic last, hold;
  logic [RW-1:0] nxt;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  always_comb begin
    case (paddr)
      RegKeyAddr: prdata = key_q;
      RegIvAddr:  prdata = iv_q;
      default:    prdata = '0;
    endcase
  end

  assign c_n = rot28(c_q, TabRot[cnt_q]);
  assign d_n = rot28(d_q, TabRot[cnt_q]);
  assign key_we = (state_q == StKey);
  assign pc1 = perm_pc1(key_q);

  dcbc_ram #(.Width(48), .Depth(Rounds)) u_keys (
    .clk_i, .we_i(key_we), .waddr_i(cnt_q), .wdata_i(perm_pc2({c_n, d_n})),
    .raddr_i(raddr), .rdata_o(rk)
  );

  assign last = (state_q == StRun) && (cnt_q == RW'(Rounds-1));
  assign hold = last && out_v_q && !rsp.ready;
  assign done = last && !hold;
  assign acc = req.valid & req.ready;
  assign req.ready = (state_q == StIdle) || done;
  assign nxt = cnt_q + 1'b1;
  always_comb begin
    if (acc) raddr = req.req_type ? RW'(Rounds-1) : '0;
    else if (hold) raddr = dir_q ? '0 : RW'(Rounds-1);
    else raddr = dir_q ? RW'(Rounds-2) - cnt_q : nxt;
  end

  assign fo = feistel(r_q, rk);
  assign fpv = perm_fp({l_q ^ fo, r_q});
  always_comb begin
    if (req.req_type == ReqDecrypt) xin = req.in_block;
    else if (req.first_block) xin = req.in_block ^ iv_q;
    else if (done && dir_q == ReqEncrypt) xin = req.in_block ^ fpv;
    else xin = req.in_block ^ enc_q;
  end
  assign ipv = perm_ip(xin);

  always_comb begin
    state_d = state_q;
    case (state_q)
      StKey:  if (cnt_q == RW'(Rounds-1)) state_d = StIdle;
      StIdle: if (acc) state_d = StRun;
      StRun:  if (done) state_d = acc ? StRun : StIdle;
      default: state_d = StIdle;
    endcase
    if (wr && paddr == RegKeyAddr) state_d = StLoad;
    else if (state_q == StLoad) state_d = StKey;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      key_q <= KeyReset;
      iv_q <= '0;
      enc_q <= '0;
      dec_q <= '0;
      cnt_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wr && paddr == RegKeyAddr) key_q <= pwdata;
      if (wr && paddr == RegIvAddr) iv_q <= pwdata;
      if (rsp.valid && rsp.ready) out_v_q <= 1'b0;
      case (state_q)
        StLoad: cnt_q <= '0;
        StKey: cnt_q <= nxt;
        StIdle: cnt_q <= '0;
        StRun: cnt_q <= done ? '0 : (hold ? cnt_q : nxt);
        default: cnt_q <= '0;
      endcase
      if (done) begin
        out_v_q <= 1'b1;
        if (dir_q == ReqDecrypt) dec_q <= blk_q;
        else enc_q <= fpv;
      end
      if (acc && req.first_block && req.req_type == ReqDecrypt) enc_q <= iv_q;
      if (acc && req.first_block && req.req_type == ReqEncrypt) dec_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StLoad) begin
      c_q <= pc1[55:28];
      d_q <= pc1[27:0];
    end else if (state_q == StKey) begin
      c_q <= c_n;
      d_q <= d_n;
    end
    if (done) out_q <= (dir_q == ReqDecrypt) ? fpv ^ chain_q : fpv;
    if (acc) begin
      dir_q <= req.req_type;
      blk_q <= req.in_block;
      if (req.first_block) chain_q <= iv_q;
      else if (done && dir_q == ReqDecrypt) chain_q <= blk_q;
      else chain_q <= dec_q;
      l_q <= ipv[63:32];
      r_q <= ipv[31:0];
    end else if (state_q == StRun && !hold) begin
      l_q <= r_q;
      r_q <= l_q ^ fo;
    end
  end

  assign rsp.valid = out_v_q;
  assign rsp.out_block = out_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni) acc |-> !key_we)
    else $error("block taken during key schedule build");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp.valid && !rsp.ready) |=> $stable(rsp.out_block))
    else $error("result overwritten while stalled");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    hold |-> !req.ready)
    else $error("accepted with result path blocked");
endmodule
